// ===== rtl/rgbnc_pkg.sv =====
`default_nettype none

package rgbnc_pkg;

	// field widths
	localparam int RAW_W   = 16;
	localparam int CHAN_W  = 8;
	localparam int SUM_W   = RAW_W + 2;
	localparam int DIST_W  = 10;
	localparam int IDX_W   = 6;
	localparam int CONF_W  = 7;

	// palette
	localparam int PALETTE_SIZE    = 33;
	localparam int PAL_ROM_ENTRIES = 33;
	localparam int SCAN_LEN = (PALETTE_SIZE < PAL_ROM_ENTRIES) ? PALETTE_SIZE
		: PAL_ROM_ENTRIES;

	// divider: one quotient bit per step
	localparam int DIV_STEPS = CHAN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CONF_W-1:0] CONF_MAX  = 7'd100;
	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	typedef struct packed {
		logic [RAW_W-1:0] red_raw;
		logic [RAW_W-1:0] green_raw;
		logic [RAW_W-1:0] blue_raw;
	} rgbnc_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_corrected;
		logic [CHAN_W-1:0] green_corrected;
		logic [CHAN_W-1:0] blue_corrected;
		logic [IDX_W-1:0]  palette_index;
		logic [CONF_W-1:0] match_confidence;
		logic              zero_sum;
	} rgbnc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_GAMMA,
		ST_SCAN,
		ST_DONE
	} rgbnc_state_t;

	typedef struct packed {
		logic             load;
		logic             div_step;
		logic             gamma_load;
		logic             scan;
		logic [IDX_W-1:0] idx;
	} rgbnc_cmd_t;

	// palette rom, r in [23:16], g in [15:8], b in [7:0]
	localparam logic [3*CHAN_W-1:0] PALETTE [PAL_ROM_ENTRIES] = '{
		24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
		24'h00FFFF, 24'hFF00FF, 24'hFFFFFF, 24'h000000,
		24'hFFA500, 24'hFFC0CB, 24'h800080, 24'h8B4513,
		24'h808080, 24'hADD8E6, 24'h006400, 24'hF5F5DC,
		24'h808000, 24'h008080, 24'h000080, 24'h800000,
		24'h8B0000, 24'h00008B, 24'h008B8B, 24'h8B008B,
		24'h8B8B00, 24'hFF8C00, 24'hE75480, 24'h5C3317,
		24'h404040, 24'h301934, 24'h004D4D, 24'h000033,
		24'h4D0000
	};

	typedef logic [CHAN_W-1:0] gamma_lut_t [256];

	// gamma 0.9: largest y with y^10 <= 255 * n^9, built at elaboration
	function automatic gamma_lut_t build_gamma();
		gamma_lut_t  lut;
		logic [95:0] rhs;
		logic [95:0] lhs;
		int          lo;
		int          hi;
		int          mid;
		for (int n = 0; n < 256; n++) begin
			rhs = 96'd255;
			for (int k = 0; k < 9; k++) begin
				rhs = rhs * 96'(n);
			end
			lo = 0;
			hi = 255;
			for (int s = 0; s < 9; s++) begin
				if (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					lhs = 96'd1;
					for (int k = 0; k < 10; k++) begin
						lhs = lhs * 96'(mid);
					end
					if (lhs <= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
			end
			lut[n] = 8'(lo);
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

`default_nettype wire

// ===== rtl/rgbnc_ctrl.sv =====
`default_nettype none

module rgbnc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	output rgbnc_pkg::rgbnc_cmd_t  cmd
);
	import rgbnc_pkg::*;

	rgbnc_state_t         state_q;
	rgbnc_state_t         state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 div_last;
	logic                 scan_last;

	assign div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign scan_last = (idx_q == IDX_W'(SCAN_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_DIV;
			ST_DIV:   if (div_last) state_d = ST_GAMMA;
			ST_GAMMA: state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.idx  = idx_q;
		busy     = 1'b1;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIV:   cmd.div_step   = 1'b1;
			ST_GAMMA: cmd.gamma_load = 1'b1;
			ST_SCAN:  cmd.scan       = 1'b1;
			ST_DONE:  done           = 1'b1;
			default:  busy           = 1'b1;
		endcase
	end

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DIV && div_cnt_q == '0))
		else $error("accepted item did not start the divider");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("done strobe longer than one cycle");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (cmd.idx < IDX_W'(SCAN_LEN)))
		else $error("palette index out of range");

	a_gamma_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gamma_load |-> $past(cmd.div_step))
		else $error("gamma load without finished division");

endmodule

`default_nettype wire

// ===== rtl/rgbnc_dpath.sv =====
`default_nettype none

module rgbnc_dpath (
	input  logic                   clk,
	input  rgbnc_pkg::rgbnc_in_t   sample,
	input  rgbnc_pkg::rgbnc_cmd_t  cmd,
	output rgbnc_pkg::rgbnc_out_t  result
);
	import rgbnc_pkg::*;

	logic [RAW_W-1:0]    raw      [3];
	logic [RAW_W+7:0]    dividend [3];
	logic [SUM_W:0]      trial    [3];
	logic                ge       [3];
	logic [SUM_W-1:0]    rem_q    [3];
	logic [CHAN_W-1:0]   dlo_q    [3];
	logic [CHAN_W-1:0]   quo_q    [3];
	logic [CHAN_W-1:0]   col_q    [3];
	logic [SUM_W-1:0]    sum_q;
	logic                zero_q;
	logic [DIST_W-1:0]   best_d_q;
	logic [IDX_W-1:0]    best_i_q;
	logic [3*CHAN_W-1:0] pal;
	logic [DIST_W-1:0]   pal_dist;
	logic [CONF_W-1:0]   conf;

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign raw[0] = sample.red_raw;
	assign raw[1] = sample.green_raw;
	assign raw[2] = sample.blue_raw;

	// restoring division of 255*raw by sum, three lanes side by side
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dividend[c] = {raw[c], 8'd0} - {8'd0, raw[c]};
			trial[c]    = {rem_q[c], dlo_q[c][CHAN_W-1]};
			ge[c]       = (trial[c] >= {1'b0, sum_q});
		end
	end

	assign pal      = PALETTE[cmd.idx];
	assign pal_dist = DIST_W'(absdiff(col_q[0], pal[23:16]))
		+ DIST_W'(absdiff(col_q[1], pal[15:8]))
		+ DIST_W'(absdiff(col_q[2], pal[7:0]));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q  <= SUM_W'(sample.red_raw) + SUM_W'(sample.green_raw)
				+ SUM_W'(sample.blue_raw);
			zero_q <= (sample.red_raw == '0) && (sample.green_raw == '0)
				&& (sample.blue_raw == '0);
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.load) begin
				rem_q[c] <= SUM_W'(dividend[c][RAW_W+7:8]);
				dlo_q[c] <= dividend[c][7:0];
				quo_q[c] <= '0;
			end else if (cmd.div_step) begin
				rem_q[c] <= ge[c] ? SUM_W'(trial[c] - {1'b0, sum_q})
					: trial[c][SUM_W-1:0];
				dlo_q[c] <= {dlo_q[c][CHAN_W-2:0], 1'b0};
				quo_q[c] <= {quo_q[c][CHAN_W-2:0], ge[c]};
			end
			if (cmd.gamma_load) begin
				col_q[c] <= zero_q ? GAMMA_LUT[0] : GAMMA_LUT[quo_q[c]];
			end
		end
		if (cmd.gamma_load) begin
			best_d_q <= DIST_INIT;
			best_i_q <= '0;
		end else if (cmd.scan && (pal_dist < best_d_q)) begin
			best_d_q <= pal_dist;
			best_i_q <= cmd.idx;
		end
	end

	assign conf = (best_d_q < DIST_W'(CONF_MAX)) ? CONF_MAX - best_d_q[CONF_W-1:0] : '0;

	assign result.red_corrected    = col_q[0];
	assign result.green_corrected  = col_q[1];
	assign result.blue_corrected   = col_q[2];
	assign result.palette_index    = best_i_q;
	assign result.match_confidence = conf;
	assign result.zero_sum         = zero_q;

endmodule

`default_nettype wire

// ===== rtl/rgb_nearest_color_classifier_unit.sv =====
// result strobe (done) comes after the divide, gamma and scan states, for one cycle
// a new item is taken only once the last one is done; busy is high from acceptance through the done cycle
// time is set by the 8-step restoring divider and the 33-entry palette scan, one entry a cycle
// reset: arst_n low clears the controller to idle, busy and done low; data regs are not reset
// the receiver cannot stall: each result is valid only in its done cycle
`default_nettype none

module rgb_nearest_color_classifier_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  rgbnc_pkg::rgbnc_in_t   sample,
	output logic                   done,
	output rgbnc_pkg::rgbnc_out_t  result
);
	import rgbnc_pkg::*;

	// command bundle from the sequencer to the datapath
	rgbnc_cmd_t cmd;

	// sequencer: idle -> divide -> gamma -> palette scan -> done
	rgbnc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath: three divider lanes, gamma table, distance unit and best-match regs
	// the item is sampled on the accepting edge, so sample may change afterwards
	rgbnc_dpath u_dpath (
		.clk    (clk),
		.sample (sample),
		.cmd    (cmd),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== bench/tb_rgb_nearest_color_classifier_unit.sv =====
module tb_rgb_nearest_color_classifier_unit;
	import rgbnc_pkg::*;

	// clocking and run bounds
	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 2;
	localparam int DRAIN_CYCLES = 60;
	localparam int RUN_LIMIT    = 8_000_000;

	// palette entries actually scanned, capped by the rom depth
	localparam int ROM_DEPTH    = 33;
	localparam int SCAN_ENTRIES = (PALETTE_SIZE < ROM_DEPTH) ? PALETTE_SIZE : ROM_DEPTH;
	localparam int CONF_FULL    = 100;

	// independent copy of the palette, r in [23:16], g in [15:8], b in [7:0]
	localparam logic [23:0] palette_rgb [ROM_DEPTH] = '{
		24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
		24'h00FFFF, 24'hFF00FF, 24'hFFFFFF, 24'h000000,
		24'hFFA500, 24'hFFC0CB, 24'h800080, 24'h8B4513,
		24'h808080, 24'hADD8E6, 24'h006400, 24'hF5F5DC,
		24'h808000, 24'h008080, 24'h000080, 24'h800000,
		24'h8B0000, 24'h00008B, 24'h008B8B, 24'h8B008B,
		24'h8B8B00, 24'hFF8C00, 24'hE75480, 24'h5C3317,
		24'h404040, 24'h301934, 24'h004D4D, 24'h000033,
		24'h4D0000
	};

	// every input known from time zero, reset held low
	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       start  = 1'b0;
	rgbnc_in_t  sample = '0;
	logic       busy;
	logic       done;
	rgbnc_out_t result;

	// predictor tables and bookkeeping
	logic [7:0]  gamma_table [256];
	rgbnc_out_t  pending_colors [$];
	int          mismatches      = 0;
	int          items_sent      = 0;
	int          results_checked = 0;
	int          zero_sum_count  = 0;
	int          burst_left      = 1;
	logic [ROM_DEPTH-1:0] index_hits = '0;

	rgb_nearest_color_classifier_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.done   (done),
		.result (result)
	);

	always #CLK_HALF clk = ~clk;

	// exact integer power, 96 bits is enough for 255^10
	function automatic logic [95:0] pow_u96(int base, int expo);
		logic [95:0] acc;
		acc = 96'd1;
		for (int k = 0; k < expo; k++) begin
			acc = acc * 96'(base);
		end
		return acc;
	endfunction

	// gamma 0.9 table: largest y with y^10 <= 255 * n^9
	// the bound grows with n, so y only ever walks upward
	task automatic build_gamma_table();
		logic [95:0] bound;
		int          y;
		y = 0;
		for (int n = 0; n < 256; n++) begin
			bound = 96'd255 * pow_u96(n, 9);
			while (y < 255 && pow_u96(y + 1, 10) <= bound) begin
				y++;
			end
			gamma_table[n] = 8'(y);
		end
	endtask

	// normalize, gamma correct and find the nearest palette color
	function automatic rgbnc_out_t classify_color(rgbnc_in_t s);
		int         raw [3];
		int         total;
		int         norm;
		int         chan [3];
		int         pal [3];
		int         dist_sum;
		int         best_dist;
		int         best_idx;
		rgbnc_out_t r;
		raw[0] = int'(s.red_raw);
		raw[1] = int'(s.green_raw);
		raw[2] = int'(s.blue_raw);
		total  = raw[0] + raw[1] + raw[2];
		for (int c = 0; c < 3; c++) begin
			norm = (total == 0) ? 0 : (255 * raw[c]) / total;
			if (norm > 255) begin
				norm = 255;
			end
			chan[c] = int'(gamma_table[norm]);
		end
		// strict compare keeps the lowest index on a tie
		best_dist = 32'h7FFF_FFFF;
		best_idx  = 0;
		for (int i = 0; i < SCAN_ENTRIES; i++) begin
			pal[0] = int'(palette_rgb[i][23:16]);
			pal[1] = int'(palette_rgb[i][15:8]);
			pal[2] = int'(palette_rgb[i][7:0]);
			dist_sum = 0;
			for (int c = 0; c < 3; c++) begin
				dist_sum += (chan[c] > pal[c]) ? chan[c] - pal[c] : pal[c] - chan[c];
			end
			if (dist_sum < best_dist) begin
				best_dist = dist_sum;
				best_idx  = i;
			end
		end
		r.red_corrected    = 8'(chan[0]);
		r.green_corrected  = 8'(chan[1]);
		r.blue_corrected   = 8'(chan[2]);
		r.palette_index    = 6'(best_idx);
		r.match_confidence = (best_dist < CONF_FULL) ? 7'(CONF_FULL - best_dist) : 7'd0;
		r.zero_sum         = (total == 0);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// field by field comparison of one result against its prediction
	task automatic compare_color(rgbnc_out_t got, rgbnc_out_t want);
		if (got.red_corrected !== want.red_corrected)
			report_mismatch($sformatf("red_corrected got %0d expected %0d",
				got.red_corrected, want.red_corrected));
		if (got.green_corrected !== want.green_corrected)
			report_mismatch($sformatf("green_corrected got %0d expected %0d",
				got.green_corrected, want.green_corrected));
		if (got.blue_corrected !== want.blue_corrected)
			report_mismatch($sformatf("blue_corrected got %0d expected %0d",
				got.blue_corrected, want.blue_corrected));
		if (got.palette_index !== want.palette_index)
			report_mismatch($sformatf("palette_index got %0d expected %0d",
				got.palette_index, want.palette_index));
		if (got.match_confidence !== want.match_confidence)
			report_mismatch($sformatf("match_confidence got %0d expected %0d",
				got.match_confidence, want.match_confidence));
		if (got.zero_sum !== want.zero_sum)
			report_mismatch($sformatf("zero_sum got %0b expected %0b",
				got.zero_sum, want.zero_sum));
	endtask

	// result monitor: done is a one-cycle strobe, sampled at the rising edge
	always @(posedge clk) begin : result_monitor
		rgbnc_out_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_colors.size() == 0) begin
				report_mismatch("result strobe with no item outstanding");
			end else begin
				want = pending_colors.pop_front();
				compare_color(result, want);
				results_checked++;
				if (result.zero_sum) begin
					zero_sum_count++;
				end
				if (result.palette_index < ROM_DEPTH) begin
					index_hits[result.palette_index] = 1'b1;
				end
			end
		end
	end

	// idle the sender, scrambling the sample bus so stale data is never trusted
	task automatic idle_cycles(int n);
		for (int k = 0; k < n; k++) begin
			@(negedge clk);
			start  <= 1'b0;
			sample <= 48'({$urandom, $urandom});
		end
	endtask

	// bursts of random length, sometimes long enough to run back to back for a while
	task automatic sender_pace();
		burst_left--;
		if (burst_left <= 0) begin
			idle_cycles($urandom_range(0, 60));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// one item: present at the falling edge, held until an edge sees busy low
	// start is left high so a following item needs no extra edge
	task automatic send_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		rgbnc_in_t s;
		s.red_raw   = r;
		s.green_raw = g;
		s.blue_raw  = b;
		@(negedge clk);
		start  <= 1'b1;
		sample <= s;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		pending_colors.push_back(classify_color(s));
		items_sent++;
		sender_pace();
	endtask

	// extremes, pure and mixed primaries, all-zero input, tiny sums
	task automatic test_directed();
		send_sample(16'd0,     16'd0,     16'd0);
		send_sample(16'hFFFF,  16'hFFFF,  16'hFFFF);
		send_sample(16'hFFFF,  16'd0,     16'd0);
		send_sample(16'd0,     16'hFFFF,  16'd0);
		send_sample(16'd0,     16'd0,     16'hFFFF);
		send_sample(16'hFFFF,  16'hFFFF,  16'd0);
		send_sample(16'd0,     16'hFFFF,  16'hFFFF);
		send_sample(16'hFFFF,  16'd0,     16'hFFFF);
		send_sample(16'd1,     16'd0,     16'd0);
		send_sample(16'd0,     16'd1,     16'd0);
		send_sample(16'd0,     16'd0,     16'd1);
		send_sample(16'd1,     16'd1,     16'd1);
		send_sample(16'hFFFF,  16'd1,     16'd1);
		send_sample(16'd1,     16'hFFFF,  16'd1);
		send_sample(16'd1,     16'd1,     16'hFFFF);
		send_sample(16'd1,     16'd2,     16'd0);
		send_sample(16'hAAAA,  16'h5555,  16'hAAAA);
		send_sample(16'h5555,  16'hAAAA,  16'h5555);
		send_sample(16'h8000,  16'h7FFF,  16'd0);
		send_sample(16'd255,   16'd165,   16'd0);
	endtask

	// full-range channels, every input bit toggles
	task automatic test_uniform_random(int n);
		for (int i = 0; i < n; i++) begin
			send_sample(16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	// channels of independent random magnitude, so one or two can dominate
	task automatic test_mixed_magnitude(int n);
		logic [15:0] ch [3];
		for (int i = 0; i < n; i++) begin
			for (int c = 0; c < 3; c++) begin
				ch[c] = 16'($urandom) & 16'((32'd1 << $urandom_range(0, 16)) - 1);
			end
			send_sample(ch[0], ch[1], ch[2]);
		end
	endtask

	// raw ratios near a chosen palette color, scaled and jittered
	task automatic test_palette_aimed(int n);
		int idx;
		int scale;
		int ch [3];
		for (int i = 0; i < n; i++) begin
			idx   = $urandom_range(0, ROM_DEPTH - 1);
			scale = $urandom_range(1, 257);
			ch[0] = int'(palette_rgb[idx][23:16]) * scale + $urandom_range(0, scale);
			ch[1] = int'(palette_rgb[idx][15:8])  * scale + $urandom_range(0, scale);
			ch[2] = int'(palette_rgb[idx][7:0])   * scale + $urandom_range(0, scale);
			for (int c = 0; c < 3; c++) begin
				if (ch[c] > 65535) begin
					ch[c] = 65535;
				end
			end
			send_sample(16'(ch[0]), 16'(ch[1]), 16'(ch[2]));
		end
	endtask

	// tiny counts: coarse ratios and frequent all-zero input
	task automatic test_small_counts(int n);
		for (int i = 0; i < n; i++) begin
			send_sample(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
				16'($urandom_range(0, 3)));
		end
	endtask

	// run limit, generous against the slowest legal pacing
	initial begin
		#RUN_LIMIT;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		build_gamma_table();

		// reset once, released on a falling edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		burst_left = $urandom_range(1, 8);
		test_directed();
		test_uniform_random(350);
		test_mixed_magnitude(300);
		test_palette_aimed(300);
		test_small_counts(80);

		// drop start so nothing more is taken, then drain
		idle_cycles(1);
		while (pending_colors.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items, checked %0d results, %0d with zero sum",
			items_sent, results_checked, zero_sum_count);
		$display("%0d of %0d palette entries chosen, %0d mismatches",
			$countones(index_hits), SCAN_ENTRIES, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
